/* rtl/sukt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sukt_pkg;

   // default table depth
   localparam int DEF_CAPACITY = 16;

   // field widths
   localparam int CMD_W    = 2;
   localparam int KEY_HI_W = 64;
   localparam int KEY_LO_W = 8;
   localparam int KEY_W    = KEY_HI_W + KEY_LO_W;
   localparam int POS_W    = 4;
   localparam int STATUS_W = 3;
   localparam int HELD_W   = 5;
   localparam int WHERE_W  = 4;

   // packed word widths, rounded up to whole bytes
   localparam int REQ_BITS   = CMD_W + KEY_W + POS_W;
   localparam int REQ_DATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS   = STATUS_W + HELD_W + WHERE_W + KEY_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   // operation codes; any code with the read bit set reads
   localparam logic [CMD_W-1:0] CMD_INSERT   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DELETE   = 2'd1;
   localparam int               CMD_READ_BIT = 1;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED  = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_FULL      = 3'd2,
      ST_DELETED   = 3'd3,
      ST_NOT_FOUND = 3'd4,
      ST_READ_OK   = 3'd5,
      ST_RANGE     = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      RD_IDX    = 2'd0,
      RD_IDX_M1 = 2'd1,
      RD_POS    = 2'd2
   } rd_sel_type;

   typedef enum logic [1:0] {
      WR_KEY         = 2'd0,
      WR_DATA_IDX    = 2'd1,
      WR_DATA_IDX_M1 = 2'd2
   } wr_sel_type;

   typedef enum logic [1:0] {
      W_ZERO = 2'd0,
      W_IDX  = 2'd1,
      W_HIT  = 2'd2,
      W_POS  = 2'd3
   } where_sel_type;

   // controller to datapath
   typedef struct packed {
      logic          latch_req;
      logic          idx_clr;
      logic          idx_set_count;
      logic          idx_inc;
      logic          idx_dec;
      logic          hit_set;
      logic          mem_rd;
      rd_sel_type    rd_sel;
      logic          mem_wr;
      wr_sel_type    wr_sel;
      logic          cnt_inc;
      logic          cnt_dec;
      logic          res_load;
      status_type    res_status;
      where_sel_type res_where;
      logic          res_data;
      logic          out_load;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic cmd_read;
      logic cmd_insert;
      logic full;
      logic pos_ok;
      logic at_end;
      logic at_hit;
      logic key_eq;
      logic key_gt;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

/* rtl/sukt_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module sukt_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire sukt_pkg::dp_status_type st,
   output sukt_pkg::ctrl_cmd_type       cmd
);
   import sukt_pkg::*;

   typedef enum logic [10:0] {
      S_IDLE   = 11'b000_0000_0001,
      S_DECODE = 11'b000_0000_0010,
      S_SRCH   = 11'b000_0000_0100,
      S_SCMP   = 11'b000_0000_1000,
      S_ISH    = 11'b000_0001_0000,
      S_ISW    = 11'b000_0010_0000,
      S_DSH    = 11'b000_0100_0000,
      S_DSW    = 11'b000_1000_0000,
      S_RDWAIT = 11'b001_0000_0000,
      S_DONE   = 11'b010_0000_0000,
      S_SPARE  = 11'b100_0000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // sequence one operation
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      cmd.res_status = ST_INSERTED;
      cmd.res_where  = W_ZERO;
      cmd.rd_sel     = RD_IDX;
      cmd.wr_sel     = WR_KEY;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.latch_req = 1'b1;
               state_in      = S_DECODE;
            end
         end
         S_DECODE: begin
            if (st.cmd_read) begin
               if (st.pos_ok) begin
                  cmd.mem_rd = 1'b1;
                  cmd.rd_sel = RD_POS;
                  state_in   = S_RDWAIT;
               end else begin
                  cmd.res_load   = 1'b1;
                  cmd.res_status = ST_RANGE;
                  cmd.res_where  = W_POS;
                  state_in       = S_DONE;
               end
            end else if (st.cmd_insert && st.full) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = ST_FULL;
               state_in       = S_DONE;
            end else begin
               cmd.idx_clr = 1'b1;
               state_in    = S_SRCH;
            end
         end
         // walk up the sorted entries
         S_SRCH: begin
            if (st.at_end) begin
               if (st.cmd_insert) begin
                  cmd.hit_set = 1'b1;
                  state_in    = S_ISH;
               end else begin
                  cmd.res_load   = 1'b1;
                  cmd.res_status = ST_NOT_FOUND;
                  state_in       = S_DONE;
               end
            end else begin
               cmd.mem_rd = 1'b1;
               cmd.rd_sel = RD_IDX;
               state_in   = S_SCMP;
            end
         end
         S_SCMP: begin
            if (st.key_eq) begin
               if (st.cmd_insert) begin
                  cmd.res_load   = 1'b1;
                  cmd.res_status = ST_DUPLICATE;
                  cmd.res_where  = W_IDX;
                  state_in       = S_DONE;
               end else begin
                  cmd.hit_set = 1'b1;
                  cmd.idx_inc = 1'b1;
                  state_in    = S_DSH;
               end
            end else if (st.key_gt) begin
               if (st.cmd_insert) begin
                  cmd.hit_set       = 1'b1;
                  cmd.idx_set_count = 1'b1;
                  state_in          = S_ISH;
               end else begin
                  cmd.res_load   = 1'b1;
                  cmd.res_status = ST_NOT_FOUND;
                  state_in       = S_DONE;
               end
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_SRCH;
            end
         end
         // open a slot: move entries up from the top
         S_ISH: begin
            if (st.at_hit) begin
               cmd.mem_wr     = 1'b1;
               cmd.wr_sel     = WR_KEY;
               cmd.cnt_inc    = 1'b1;
               cmd.res_load   = 1'b1;
               cmd.res_status = ST_INSERTED;
               cmd.res_where  = W_HIT;
               state_in       = S_DONE;
            end else begin
               cmd.mem_rd = 1'b1;
               cmd.rd_sel = RD_IDX_M1;
               state_in   = S_ISW;
            end
         end
         S_ISW: begin
            cmd.mem_wr  = 1'b1;
            cmd.wr_sel  = WR_DATA_IDX;
            cmd.idx_dec = 1'b1;
            state_in    = S_ISH;
         end
         // close the gap: move entries down
         S_DSH: begin
            if (st.at_end) begin
               cmd.cnt_dec    = 1'b1;
               cmd.res_load   = 1'b1;
               cmd.res_status = ST_DELETED;
               cmd.res_where  = W_HIT;
               state_in       = S_DONE;
            end else begin
               cmd.mem_rd = 1'b1;
               cmd.rd_sel = RD_IDX;
               state_in   = S_DSW;
            end
         end
         S_DSW: begin
            cmd.mem_wr  = 1'b1;
            cmd.wr_sel  = WR_DATA_IDX_M1;
            cmd.idx_inc = 1'b1;
            state_in    = S_DSH;
         end
         S_RDWAIT: begin
            cmd.res_load   = 1'b1;
            cmd.res_status = ST_READ_OK;
            cmd.res_where  = W_POS;
            cmd.res_data   = 1'b1;
            state_in       = S_DONE;
         end
         // hand the result to the output register
         S_DONE: begin
            if (st.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // a request is only taken in idle
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.latch_req |-> state_ff == S_IDLE)
      else $error("request latched outside idle");

   // every output load returns the controller to idle
   a_load_done: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> state_ff == S_IDLE)
      else $error("output load did not return to idle");

   // a write and a count increment never happen during search
   a_no_wr_search: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SRCH || state_ff == S_SCMP) |-> !cmd.mem_wr && !cmd.cnt_inc)
      else $error("store written during search");

endmodule

`default_nettype wire

/* rtl/sukt_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module sukt_dp #(
   parameter int CAPACITY = sukt_pkg::DEF_CAPACITY
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic [sukt_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [sukt_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   input  wire sukt_pkg::ctrl_cmd_type              cmd,
   output sukt_pkg::dp_status_type                  st
);
   import sukt_pkg::*;

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int WIDE_W = CNT_W + POS_W + HELD_W;

   logic [CMD_W-1:0]      cmd_ff,    cmd_in;
   logic [KEY_W-1:0]      key_ff,    key_in;
   logic [POS_W-1:0]      pos_ff,    pos_in;
   logic [CNT_W-1:0]      idx_ff,    idx_in;
   logic [CNT_W-1:0]      hit_ff,    hit_in;
   logic [CNT_W-1:0]      count_ff,  count_in;
   status_type            res_status_ff, res_status_in;
   logic [WHERE_W-1:0]    res_where_ff,  res_where_in;
   logic [KEY_W-1:0]      res_data_ff,   res_data_in;
   logic                  rsp_valid_ff,  rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff,   rsp_data_in;

   logic [KEY_W-1:0]      store_ff [CAPACITY];
   logic [KEY_W-1:0]      rd_data_ff;
   logic [IDX_W-1:0]      rd_addr;
   logic [IDX_W-1:0]      wr_addr;
   logic [KEY_W-1:0]      wr_data;
   logic [CNT_W-1:0]      idx_m1;
   logic [WIDE_W-1:0]     idx_wide, hit_wide, pos_wide, count_wide;

   assign idx_m1     = idx_ff - CNT_W'(1);
   assign idx_wide   = WIDE_W'(idx_ff);
   assign hit_wide   = WIDE_W'(hit_ff);
   assign pos_wide   = WIDE_W'(pos_ff);
   assign count_wide = WIDE_W'(count_ff);

   // select store addresses and write data
   always_comb begin
      case (cmd.rd_sel)
         RD_IDX:    rd_addr = idx_ff[IDX_W-1:0];
         RD_IDX_M1: rd_addr = idx_m1[IDX_W-1:0];
         RD_POS:    rd_addr = pos_wide[IDX_W-1:0];
         default:   rd_addr = idx_ff[IDX_W-1:0];
      endcase
      case (cmd.wr_sel)
         WR_KEY:         wr_addr = hit_ff[IDX_W-1:0];
         WR_DATA_IDX:    wr_addr = idx_ff[IDX_W-1:0];
         WR_DATA_IDX_M1: wr_addr = idx_m1[IDX_W-1:0];
         default:        wr_addr = idx_ff[IDX_W-1:0];
      endcase
      wr_data = (cmd.wr_sel == WR_KEY) ? key_ff : rd_data_ff;
   end

   // name store, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.mem_wr) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (cmd.mem_rd) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   // request fields, walk index, hit index and fill count
   always_comb begin
      cmd_in = cmd_ff;
      key_in = key_ff;
      pos_in = pos_ff;
      if (cmd.latch_req) begin
         cmd_in = req_tdata[CMD_W-1:0];
         key_in = {req_tdata[CMD_W +: KEY_HI_W], req_tdata[CMD_W + KEY_HI_W +: KEY_LO_W]};
         pos_in = req_tdata[CMD_W + KEY_W +: POS_W];
      end
      idx_in = idx_ff;
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_set_count) begin
         idx_in = count_ff;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + CNT_W'(1);
      end else if (cmd.idx_dec) begin
         idx_in = idx_m1;
      end
      hit_in = cmd.hit_set ? idx_ff : hit_ff;
      count_in = count_ff;
      if (cmd.cnt_inc) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // result and output register
   always_comb begin
      res_status_in = res_status_ff;
      res_where_in  = res_where_ff;
      res_data_in   = res_data_ff;
      if (cmd.res_load) begin
         res_status_in = cmd.res_status;
         res_data_in   = cmd.res_data ? rd_data_ff : '0;
         case (cmd.res_where)
            W_ZERO:  res_where_in = '0;
            W_IDX:   res_where_in = idx_wide[WHERE_W-1:0];
            W_HIT:   res_where_in = hit_wide[WHERE_W-1:0];
            W_POS:   res_where_in = pos_ff;
            default: res_where_in = '0;
         endcase
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_DATA_W'({res_data_ff[KEY_LO_W-1:0],
                                     res_data_ff[KEY_W-1:KEY_LO_W],
                                     res_where_ff,
                                     count_wide[HELD_W-1:0],
                                     res_status_ff});
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      pos_ff        <= pos_in;
      idx_ff        <= idx_in;
      hit_ff        <= hit_in;
      res_status_ff <= res_status_in;
      res_where_ff  <= res_where_in;
      res_data_ff   <= res_data_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // status toward the controller
   always_comb begin
      st.cmd_read   = cmd_ff[CMD_READ_BIT];
      st.cmd_insert = (cmd_ff == CMD_INSERT);
      st.full       = (count_ff == CNT_W'(CAPACITY));
      st.pos_ok     = (pos_wide < count_wide);
      st.at_end     = (idx_ff == count_ff);
      st.at_hit     = (idx_ff == hit_ff);
      st.key_eq     = (rd_data_ff == key_ff);
      st.key_gt     = (rd_data_ff > key_ff);
      st.out_free   = !rsp_valid_ff || rsp_tready;
   end

   // fill count stays within the table
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_wide <= WIDE_W'(CAPACITY))
      else $error("fill count beyond capacity");

   // an insert never grows a full table
   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      cmd.cnt_inc |-> !st.full)
      else $error("insert into full table");

   // a delete never shrinks an empty table
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      cmd.cnt_dec |-> count_ff != '0)
      else $error("delete from empty table");

   // a loaded result is offered on the next cycle
   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff)
      else $error("loaded result not offered");

endmodule

`default_nettype wire

/* rtl/sorted_unique_key_table.sv */
// Sorted table of unique nine-byte names.
// Request channel (req_): one word per operation: insert a name, delete a
// name, or read the entry at an index. Response channel (rsp_): exactly one
// word per request, carrying status, fill count after the operation, the
// index concerned and, for a read, the stored name.
// Names are compared as 72-bit unsigned values and kept in ascending order
// in a single-port-write, registered-read store of CAPACITY entries.
// A read passes through decode, a store read and the result register before
// the response register is loaded. Insert and delete walk the store one entry
// at a time (address, then compare), and shifting the tail reads and then
// writes each moved entry; the registered store read sets this pace.
// req_tready is high only while idle, from the cycle after the response is
// loaded, so a new request is not taken while one is still in progress.
// A finished response waits in the output register; the next request is
// accepted meanwhile, but its result is held until the register frees up.
// Reset empties the table at once (fill count to zero); no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module sorted_unique_key_table #(
   parameter int CAPACITY = sukt_pkg::DEF_CAPACITY
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // cmd[1:0], key_high[65:2], key_low[73:66], position[77:74], zero pad
   input  wire logic [sukt_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // status[2:0], entries_held[7:3], where[11:8], out_high[75:12],
   // out_low[83:76], zero pad
   output logic [sukt_pkg::RSP_DATA_W-1:0]       rsp_tdata
);
   import sukt_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type st;

   sukt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   sukt_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .st         (st)
   );

endmodule

`default_nettype wire

/* tb/sv/sorted_unique_key_table_tb.sv */
`timescale 1ns / 1ps

module sorted_unique_key_table_tb;
   import sukt_pkg::*;

   localparam int CAP            = DEF_CAPACITY;
   localparam int RANDOM_ITEMS   = 1750;
   localparam int POOL_SIZE      = 24;
   localparam int IDLE_LIMIT     = 4000;
   localparam int DRAIN_CYCLES   = 64;

   // read codes: only the high bit of cmd selects read
   localparam logic [CMD_W-1:0] CMD_READ     = 2'd2;
   localparam logic [CMD_W-1:0] CMD_READ_ALT = 2'd3;

   // traffic mix of one random phase
   typedef enum int {
      MIX_FILL,
      MIX_DRAIN,
      MIX_EVEN
   } traffic_mix_type;

   typedef struct {
      status_type          status;
      logic [HELD_W-1:0]   held;
      logic [WHERE_W-1:0]  where;
      logic [KEY_HI_W-1:0] name_hi;
      logic [KEY_LO_W-1:0] name_lo;
   } table_reply_type;

   // Sorted name table predictor plus the queue of replies still owed.
   class name_table_checker;
      logic [KEY_W-1:0] names [CAP];
      int               held;
      table_reply_type  pending_replies [$];
      int unsigned      errors;

      function new();
         held   = 0;
         errors = 0;
      endfunction

      // apply one accepted request and queue the reply it must produce
      function void note_request(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                                 logic [POS_W-1:0] pos);
         table_reply_type r;
         int              hit;
         int              i;
         r.status  = ST_INSERTED;
         r.where   = '0;
         r.name_hi = '0;
         r.name_lo = '0;
         hit       = -1;
         for (i = 0; i < held; i++) begin
            if (hit < 0 && names[i] == key) hit = i;
         end
         if (cmd[CMD_READ_BIT]) begin
            r.where = pos;
            if (int'(pos) < held) begin
               r.status               = ST_READ_OK;
               {r.name_hi, r.name_lo} = names[pos];
            end else begin
               r.status = ST_RANGE;
            end
         end else if (cmd == CMD_INSERT) begin
            // a full table refuses before any search
            if (held >= CAP) begin
               r.status = ST_FULL;
            end else if (hit >= 0) begin
               r.status = ST_DUPLICATE;
               r.where  = hit[WHERE_W-1:0];
            end else begin
               i = held;
               while (i > 0 && names[i-1] > key) begin
                  names[i] = names[i-1];
                  i--;
               end
               names[i] = key;
               held++;
               r.where = i[WHERE_W-1:0];
            end
         end else begin
            if (hit < 0) begin
               r.status = ST_NOT_FOUND;
            end else begin
               // close the gap
               for (i = hit; i + 1 < held; i++) names[i] = names[i+1];
               held--;
               r.status = ST_DELETED;
               r.where  = hit[WHERE_W-1:0];
            end
         end
         r.held = held[HELD_W-1:0];
         pending_replies.push_back(r);
      endfunction

      // compare one response word with the oldest reply owed
      function void check_response(logic [RSP_DATA_W-1:0] word);
         table_reply_type r;
         if (pending_replies.size() == 0) begin
            $error("response word with no request pending: %h", word);
            errors++;
            return;
         end
         r = pending_replies.pop_front();
         if (word[2:0] !== r.status) begin
            $error("status expected %0d actual %0d", r.status, word[2:0]);
            errors++;
         end
         if (word[7:3] !== r.held) begin
            $error("entries_held expected %0d actual %0d", r.held, word[7:3]);
            errors++;
         end
         if (word[11:8] !== r.where) begin
            $error("where expected %0d actual %0d", r.where, word[11:8]);
            errors++;
         end
         if (word[75:12] !== r.name_hi) begin
            $error("out_high expected %h actual %h", r.name_hi, word[75:12]);
            errors++;
         end
         if (word[83:76] !== r.name_lo) begin
            $error("out_low expected %h actual %h", r.name_lo, word[83:76]);
            errors++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   name_table_checker     book;
   logic [KEY_W-1:0]      key_pool [POOL_SIZE];
   int unsigned           idle_cycles;

   sorted_unique_key_table DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 8 ns clock
   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // draw a name: raw random, short printable text, or an edge-heavy shape
   function automatic logic [KEY_W-1:0] draw_key();
      logic [KEY_W-1:0] key;
      int               len;
      int               b;
      key = '0;
      case ($urandom_range(0, 3))
         0: key = {$urandom, $urandom, 8'($urandom)};
         1: begin
            len = $urandom_range(1, 9);
            for (b = 0; b < len; b++) key[KEY_W-1-8*b -: 8] = 8'($urandom_range(8'h20, 8'h7e));
         end
         2: key = {8'($urandom_range(8'h41, 8'h44)), 56'h0, 8'($urandom_range(0, 3))};
         default: key = {{56{1'b1}}, 8'($urandom), 8'($urandom)};
      endcase
      return key;
   endfunction

   // hold the word until the block takes it, then book it
   task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                               input logic [POS_W-1:0] pos, input bit quiet);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 19);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {{(REQ_DATA_W-REQ_BITS){1'b0}}, pos, key[KEY_LO_W-1:0],
                    key[KEY_W-1:KEY_LO_W], cmd};
      do @(posedge clock); while (!req_tready);
      book.note_request(cmd, key, pos);
   endtask

   // check every response word taken
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) book.check_response(rsp_tdata);
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // receiver: stall a random while before each word, calm stretches too
   initial begin
      int stall;
      int stretch;
      bit calm;
      rsp_tready = 1'b0;
      stretch    = 0;
      calm       = 1'b0;
      @(negedge reset);
      forever begin
         if (stretch == 0) begin
            stretch = $urandom_range(10, 40);
            calm    = ($urandom_range(0, 2) == 0);
         end
         stretch--;
         stall = calm ? 0 : $urandom_range(0, 19);
         repeat (stall) begin
            @(negedge clock);
            rsp_tready = 1'b0;
         end
         @(negedge clock);
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // stimulus
   initial begin
      int              sent;
      int              n;
      int              r;
      traffic_mix_type mix;
      bit              quiet;
      logic [CMD_W-1:0] cmd;
      logic [KEY_W-1:0] key;
      book        = new();
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty table, extremes, ordering, duplicates, cmd 3, full table
      send_request(CMD_READ, '0, 4'd0, 1'b0);
      send_request(CMD_DELETE, '0, 4'd0, 1'b0);
      send_request(CMD_INSERT, {KEY_W{1'b1}}, 4'd15, 1'b0);
      send_request(CMD_INSERT, '0, 4'd0, 1'b1);
      send_request(CMD_INSERT, {64'h414C494345000000, 8'h00}, 4'd0, 1'b1);
      // nonzero byte after a zero byte still counts as a distinct name
      send_request(CMD_INSERT, {64'h414C494345000000, 8'h01}, 4'd0, 1'b0);
      send_request(CMD_INSERT, {64'h414C494345000001, 8'h00}, 4'd0, 1'b0);
      send_request(CMD_INSERT, {64'h414C494345000000, 8'h00}, 4'd0, 1'b0);
      send_request(CMD_READ, '0, 4'd0, 1'b0);
      send_request(CMD_READ_ALT, {KEY_W{1'b1}}, 4'd4, 1'b0);
      send_request(CMD_READ, '0, 4'd5, 1'b1);
      send_request(CMD_READ, '0, 4'd15, 1'b0);
      send_request(CMD_DELETE, {KEY_W{1'b1}}, 4'd0, 1'b0);
      send_request(CMD_DELETE, '0, 4'd0, 1'b0);
      send_request(CMD_DELETE, {64'h414C494345000000, 8'h02}, 4'd0, 1'b0);
      send_request(CMD_INSERT, {64'h0, 8'hff}, 4'd0, 1'b0);
      send_request(CMD_INSERT, {64'h8000000000000000, 8'h00}, 4'd0, 1'b0);
      while (book.held < CAP) send_request(CMD_INSERT, draw_key(), 4'($urandom), 1'b1);
      // full table refuses even a name already present
      send_request(CMD_INSERT, {64'h414C494345000000, 8'h00}, 4'd0, 1'b0);
      send_request(CMD_READ, '0, 4'd15, 1'b0);
      send_request(CMD_DELETE, {64'h414C494345000001, 8'h00}, 4'd0, 1'b0);

      // random phases over a slowly changing pool of names
      for (n = 0; n < POOL_SIZE; n++) key_pool[n] = draw_key();
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         mix   = traffic_mix_type'($urandom_range(0, 2));
         quiet = ($urandom_range(0, 3) == 0);
         repeat (8) key_pool[$urandom_range(0, POOL_SIZE-1)] = draw_key();
         repeat ($urandom_range(40, 90)) begin
            r = $urandom_range(0, 99);
            case (mix)
               MIX_FILL:  cmd = (r < 70) ? CMD_INSERT : (r < 85) ? CMD_DELETE : CMD_READ;
               MIX_DRAIN: cmd = (r < 15) ? CMD_INSERT : (r < 75) ? CMD_DELETE : CMD_READ;
               default:   cmd = (r < 40) ? CMD_INSERT : (r < 70) ? CMD_DELETE : CMD_READ;
            endcase
            if (cmd == CMD_READ && $urandom_range(0, 4) == 0) cmd = CMD_READ_ALT;
            key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, POOL_SIZE-1)]
                                               : draw_key();
            send_request(cmd, key, 4'($urandom), quiet);
            sent++;
         end
      end
      @(negedge clock);
      req_tvalid = 1'b0;

      // wait for every reply, then let the block settle
      while (book.pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (book.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

/* sorted_unique_key_table.f */
rtl/sukt_pkg.sv
rtl/sukt_ctrl.sv
rtl/sukt_dp.sv
rtl/sorted_unique_key_table.sv
tb/sv/sorted_unique_key_table_tb.sv
